// File: src/gufwm_pkg.sv
// Shared types and constants for the grid union-find wall merge block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gufwm_pkg;

    localparam int DEF_MAX_COLS = 32;
    localparam int DEF_MAX_ROWS = 32;

    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CELL_W     = 10;
    localparam int SIDE_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    // side codes of a cell
    localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd3;

    localparam int FQ_DEPTH = 2;
    localparam int RQ_DEPTH = 2;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        logic       downward;
    } t_in;

    typedef struct packed {
        logic              opened;
        logic              bad_wall;
        logic [CELL_W-1:0] first_cell;
        logic [CELL_W-1:0] second_cell;
        logic [SIDE_W-1:0] first_side;
        logic [SIDE_W-1:0] second_side;
    } t_out;

endpackage

// File: src/gufwm_front.sv
// Front end: grid size clamping, wall classification and cell indexing,
// feeding a short job queue towards the back end. Depends on gufwm_pkg.
`timescale 1ns / 1ps

module gufwm_front
    import gufwm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int CW = $clog2(MAX_COLS * MAX_ROWS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_grid_width,
    input  logic [CFG_DATA_W-1:0] i_grid_height,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_in                   i_in,
    output logic                  o_job_valid,
    input  logic                  i_job_take,
    output t_out                  o_job_res,
    output logic [CW-1:0]         o_job_a,
    output logic [CW-1:0]         o_job_b
);

    localparam int PW = $clog2(FQ_DEPTH) > 0 ? $clog2(FQ_DEPTH) : 1;
    localparam int NW = $clog2(FQ_DEPTH + 1);

    logic [CFG_DATA_W-1:0] w_eff, h_eff;
    logic [5:0]            row1, col1, row2, col2;
    logic [11:0]           idx_a, idx_b;
    logic                  bad;
    t_out                  res;
    logic                  wr, rd;

    t_out          r_q_res [FQ_DEPTH];
    logic [CW-1:0] r_q_a   [FQ_DEPTH];
    logic [CW-1:0] r_q_b   [FQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    // out-of-range sizes: zero counts as one, above the maximum counts as the maximum
    always_comb begin
        w_eff = i_grid_width;
        if (i_grid_width == '0) begin
            w_eff = CFG_DATA_W'(1);
        end else if (int'(i_grid_width) > MAX_COLS) begin
            w_eff = CFG_DATA_W'(MAX_COLS);
        end
        h_eff = i_grid_height;
        if (i_grid_height == '0) begin
            h_eff = CFG_DATA_W'(1);
        end else if (int'(i_grid_height) > MAX_ROWS) begin
            h_eff = CFG_DATA_W'(MAX_ROWS);
        end
    end

    assign row1 = {1'b0, i_in.row};
    assign col1 = {1'b0, i_in.col};
    assign row2 = row1 + 6'(i_in.downward);
    assign col2 = col1 + 6'(!i_in.downward);
    assign bad  = (row1 >= h_eff) || (col1 >= w_eff) || (row2 >= h_eff) || (col2 >= w_eff);

    assign idx_a = 12'(row1) * 12'(w_eff) + 12'(col1);
    assign idx_b = 12'(row2) * 12'(w_eff) + 12'(col2);

    always_comb begin
        res = '0;
        res.bad_wall = bad;
        if (!bad) begin
            res.first_cell  = CELL_W'(idx_a);
            res.second_cell = CELL_W'(idx_b);
            res.first_side  = i_in.downward ? SIDE_BOTTOM : SIDE_RIGHT;
            res.second_side = i_in.downward ? SIDE_TOP : SIDE_LEFT;
        end
    end

    assign o_full      = (r_cnt == NW'(FQ_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign wr          = i_push && !o_full;
    assign rd          = i_job_take && o_job_valid;

    assign o_job_res = r_q_res[r_rp];
    assign o_job_a   = r_q_a[r_rp];
    assign o_job_b   = r_q_b[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q_res[r_wp] <= res;
            r_q_a[r_wp]   <= CW'(idx_a);
            r_q_b[r_wp]   <= CW'(idx_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (int'(r_wp) == FQ_DEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (rd) begin
                r_rp <= (int'(r_rp) == FQ_DEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + NW'(wr) - NW'(rd);
        end
    end

endmodule

// File: src/gufwm_back.sv
// Back end: parent store, root walker, link write and result queue.
// Depends on gufwm_pkg; takes jobs from gufwm_front.
`timescale 1ns / 1ps

module gufwm_back
    import gufwm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int CELLS = MAX_COLS * MAX_ROWS,
    localparam int CW = $clog2(CELLS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_clearing,
    input  logic          i_job_valid,
    output logic          o_job_take,
    input  t_out          i_job_res,
    input  logic [CW-1:0] i_job_a,
    input  logic [CW-1:0] i_job_b,
    output logic          o_empty,
    input  logic          i_pop,
    output t_out          o_out
);

    localparam int PW = $clog2(RQ_DEPTH) > 0 ? $clog2(RQ_DEPTH) : 1;
    localparam int NW = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_A,
        S_WALK_B
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_clr;
    logic [CW-1:0] r_cur, r_b, r_ra;
    t_out          r_res;

    logic [CW-1:0] r_mem [CELLS];
    logic [CW-1:0] r_rdata;

    logic          rq_full, root_hit, link;
    logic          mem_we;
    logic [CW-1:0] mem_waddr, mem_wdata, rd_addr;
    logic          res_push, res_pop;
    t_out          res_data;

    t_out          r_rq [RQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign rq_full    = (r_cnt == NW'(RQ_DEPTH));
    assign o_clearing = (r_state == S_CLEAR);
    assign o_job_take = (r_state == S_IDLE) && i_job_valid && !rq_full;
    assign root_hit   = (r_rdata == r_cur);
    assign link       = (r_cur != r_ra);

    always_comb begin
        case (r_state)
            S_IDLE:   rd_addr = i_job_a;
            S_WALK_A: rd_addr = root_hit ? r_b : r_rdata;
            default:  rd_addr = r_rdata;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cur;
        mem_wdata = r_ra;
        res_push  = 1'b0;
        res_data  = i_job_res;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = r_clr;
            end
            S_IDLE: begin
                res_push = o_job_take && i_job_res.bad_wall;
            end
            S_WALK_B: begin
                if (root_hit) begin
                    // second root goes under the first
                    mem_we          = link;
                    res_push        = 1'b1;
                    res_data        = r_res;
                    res_data.opened = link;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_job_take && !i_job_res.bad_wall) begin
                        r_cur   <= i_job_a;
                        r_b     <= i_job_b;
                        r_res   <= i_job_res;
                        r_state <= S_WALK_A;
                    end
                end
                S_WALK_A: begin
                    if (root_hit) begin
                        r_ra    <= r_cur;
                        r_cur   <= r_b;
                        r_state <= S_WALK_B;
                    end else begin
                        r_cur <= r_rdata;
                    end
                end
                S_WALK_B: begin
                    if (root_hit) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cur <= r_rdata;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // result queue
    assign o_empty = (r_cnt == '0);
    assign res_pop = i_pop && !o_empty;
    assign o_out   = r_rq[r_rp];

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_wp] <= res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (res_push) begin
                r_wp <= (int'(r_wp) == RQ_DEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (res_pop) begin
                r_rp <= (int'(r_rp) == RQ_DEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + NW'(res_push) - NW'(res_pop);
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !rq_full)
        else $error("result pushed into a full queue");

    a_link_only_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != S_CLEAR) |-> (r_state == S_WALK_B && root_hit && link))
        else $error("parent store written outside a link");

    a_no_take_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> (!o_job_take && !res_push))
        else $error("job taken during clearing pass");

    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_take && !i_job_res.bad_wall) |=> (r_state == S_WALK_A && r_cur == $past(i_job_a)))
        else $error("walk did not start at first cell");

endmodule

// File: src/grid_union_find_wall_merge_top.sv
// A bad wall is put in the result queue as it is taken, with no walk; a valid wall
// is walked from both cells to their roots, da and db being the chain depths from both cells to
// their roots, one parent store read per step. The back end takes a new wall only once
// the walk of the last one is done, as the parent store has a single read port.
// Reset: synchronous, active low; configuration returns to 32 x 32 and a clearing
// pass sets the parent store to identity, full held high.
`timescale 1ns / 1ps

module grid_union_find_wall_merge_top
    import gufwm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_in                   i_in,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_out                  o_out
);

    localparam int CW = $clog2(MAX_COLS * MAX_ROWS);

    logic [CFG_DATA_W-1:0] r_grid_width, r_grid_height;
    logic                  clearing, front_full;
    logic                  job_valid, job_take;
    t_out                  job_res;
    logic [CW-1:0]         job_a, job_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_DATA_W'(32);
            r_grid_height <= CFG_DATA_W'(32);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_full = front_full || clearing;

    gufwm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_push        (i_push && !clearing),
        .o_full        (front_full),
        .i_in          (i_in),
        .o_job_valid   (job_valid),
        .i_job_take    (job_take),
        .o_job_res     (job_res),
        .o_job_a       (job_a),
        .o_job_b       (job_b)
    );

    gufwm_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_job_valid (job_valid),
        .o_job_take  (job_take),
        .i_job_res   (job_res),
        .i_job_a     (job_a),
        .i_job_b     (job_b),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out       (o_out)
    );

endmodule

// File: test/grid_union_find_wall_merge_top_tb.sv
`timescale 1ns / 1ps
// Testbench for grid_union_find_wall_merge_top: walls and grid size writes are queued for a
// clocked driver, and a behavioural union-find checks each report in order.
// Depends on gufwm_pkg and the block under src.

module grid_union_find_wall_merge_top_tb;
    import gufwm_pkg::*;

    localparam int CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;

    typedef enum logic [1:0] {JOB_WALL, JOB_CFG, JOB_DRAIN} t_job_kind;

    typedef struct packed {
        t_job_kind             kind;
        t_in                   wall;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_job;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we_q   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx_q  = '0;
    logic [CFG_DATA_W-1:0] cfg_data_q = '0;
    logic                  push_q     = 1'b0;
    t_in                   in_q       = '0;
    logic                  pop_q      = 1'b0;
    logic                  full;
    logic                  empty;
    t_out                  out_w;

    // behavioural copy of the parent store and grid size registers
    logic [CELL_W-1:0]     parent_m [CELLS];
    logic [CFG_DATA_W-1:0] width_m;
    logic [CFG_DATA_W-1:0] height_m;

    t_job wall_jobs[$];
    t_out wall_reports[$];

    int   n_mismatch = 0;
    int   n_reported = 0;
    int   hold_left  = 0;
    logic hold_armed = 1'b1;
    int   send_gap   = 0;
    int   send_run   = 0;
    int   recv_gap   = 0;
    int   recv_run   = 0;
    int   stim_w;
    int   stim_h;

    grid_union_find_wall_merge_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we_q),
        .i_cfg_idx  (cfg_idx_q),
        .i_cfg_data (cfg_data_q),
        .i_push     (push_q),
        .o_full     (full),
        .i_in       (in_q),
        .o_empty    (empty),
        .i_pop      (pop_q),
        .o_out      (out_w)
    );

    always #5 clk = ~clk;

    function automatic int fit_dim(logic [CFG_DATA_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (int'(v) > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic logic [CELL_W-1:0] root_of(logic [CELL_W-1:0] start_cell);
        logic [CELL_W-1:0] cur;
        int                steps;
        cur   = start_cell;
        steps = 0;
        while (steps < CELLS && parent_m[cur] != cur) begin
            cur = parent_m[cur];
            steps++;
        end
        return cur;
    endfunction

    // open one wall: report plus link of the second root under the first
    function automatic t_out merge_wall(t_in w);
        t_out              rep;
        int                gw;
        int                gh;
        int                r1;
        int                c1;
        int                r2;
        int                c2;
        logic [CELL_W-1:0] a;
        logic [CELL_W-1:0] b;
        logic [CELL_W-1:0] ra;
        logic [CELL_W-1:0] rb;
        gw  = fit_dim(width_m, DEF_MAX_COLS);
        gh  = fit_dim(height_m, DEF_MAX_ROWS);
        r1  = int'(w.row);
        c1  = int'(w.col);
        r2  = w.downward ? r1 + 1 : r1;
        c2  = w.downward ? c1 : c1 + 1;
        rep = '0;
        if (r1 >= gh || c1 >= gw || r2 >= gh || c2 >= gw) begin
            rep.bad_wall = 1'b1;
            return rep;
        end
        a  = CELL_W'(r1 * gw + c1);
        b  = CELL_W'(r2 * gw + c2);
        ra = root_of(a);
        rb = root_of(b);
        if (ra != rb) begin
            parent_m[rb] = ra;
            rep.opened   = 1'b1;
        end
        rep.first_cell  = a;
        rep.second_cell = b;
        rep.first_side  = w.downward ? SIDE_BOTTOM : SIDE_RIGHT;
        rep.second_side = w.downward ? SIDE_TOP : SIDE_LEFT;
        return rep;
    endfunction

    // per-transfer pause, with occasional runs of back-to-back transfers
    function automatic int pick_pause(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic add_wall(int r, int c, int d);
        t_job j;
        j               = '0;
        j.kind          = JOB_WALL;
        j.wall.row      = 5'(r);
        j.wall.col      = 5'(c);
        j.wall.downward = d[0];
        wall_jobs       = {wall_jobs, j};
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int value);
        t_job j;
        j         = '0;
        j.kind    = JOB_CFG;
        j.idx     = idx;
        j.data    = CFG_DATA_W'(value);
        wall_jobs = {wall_jobs, j};
    endtask

    task automatic add_drain();
        t_job j;
        j         = '0;
        j.kind    = JOB_DRAIN;
        wall_jobs = {wall_jobs, j};
    endtask

    task automatic set_grid(int w, int h);
        add_cfg(CFG_GRID_WIDTH, w);
        add_cfg(CFG_GRID_HEIGHT, h);
        stim_w = fit_dim(CFG_DATA_W'(w), DEF_MAX_COLS);
        stim_h = fit_dim(CFG_DATA_W'(h), DEF_MAX_ROWS);
    endtask

    // mostly walls inside the grid, the rest raw 5-bit noise
    task automatic random_walls(int n);
        int i;
        int d;
        int r;
        int c;
        for (i = 0; i < n; i++) begin
            d = $urandom_range(0, 1);
            if ($urandom_range(0, 99) < 12 || (stim_w < 2 && stim_h < 2)) begin
                add_wall($urandom_range(0, 31), $urandom_range(0, 31), d);
            end else begin
                if (stim_h < 2) d = 0;
                else if (stim_w < 2) d = 1;
                r = $urandom_range(0, stim_h - 1 - d);
                c = $urandom_range(0, stim_w - 2 + d);
                add_wall(r, c, d);
            end
        end
    endtask

    // sender: walls and register writes, writes only once all reports are back
    always @(posedge clk) begin : drive
        logic nx_push;
        logic nx_we;
        t_job job;
        t_out rep_w;
        if (!rst_n) begin
            push_q   <= 1'b0;
            cfg_we_q <= 1'b0;
        end else begin
            nx_push = push_q;
            nx_we   = 1'b0;
            if (push_q && !full) begin
                rep_w        = merge_wall(in_q);
                wall_reports = {wall_reports, rep_w};
                nx_push      = 1'b0;
                send_gap     = pick_pause(send_run);
            end
            if (!nx_push && wall_jobs.size() != 0) begin
                job = wall_jobs[0];
                case (job.kind)
                    JOB_WALL: begin
                        if (send_gap > 0) begin
                            send_gap--;
                        end else begin
                            in_q    <= job.wall;
                            nx_push = 1'b1;
                            void'(wall_jobs.pop_front());
                        end
                    end
                    JOB_CFG: begin
                        if (wall_reports.size() == 0) begin
                            nx_we = 1'b1;
                            cfg_idx_q  <= job.idx;
                            cfg_data_q <= job.data;
                            if (job.idx == CFG_GRID_WIDTH) width_m = job.data;
                            else height_m = job.data;
                            void'(wall_jobs.pop_front());
                        end
                    end
                    JOB_DRAIN: begin
                        if (wall_reports.size() == 0) void'(wall_jobs.pop_front());
                    end
                    default: begin
                        void'(wall_jobs.pop_front());
                    end
                endcase
            end
            push_q   <= nx_push;
            cfg_we_q <= nx_we;
        end
    end

    // receiver: pops with random pauses, checks every report against the oldest prediction
    always @(posedge clk) begin : observe
        logic nx_pop;
        t_out want;
        if (!rst_n) begin
            pop_q <= 1'b0;
        end else begin
            nx_pop = pop_q;
            if (pop_q && !empty) begin
                n_reported <= n_reported + 1;
                if (wall_reports.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("report with nothing pending: opened %0d bad %0d cells %0d/%0d",
                                 out_w.opened, out_w.bad_wall, out_w.first_cell,
                                 out_w.second_cell);
                end else begin
                    want = wall_reports.pop_front();
                    if (out_w.opened !== want.opened || out_w.bad_wall !== want.bad_wall ||
                        out_w.first_cell !== want.first_cell ||
                        out_w.second_cell !== want.second_cell ||
                        out_w.first_side !== want.first_side ||
                        out_w.second_side !== want.second_side) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $write("report mismatch: expected opened %0d bad %0d cells %0d/%0d",
                                   want.opened, want.bad_wall, want.first_cell,
                                   want.second_cell);
                            $write(" sides %0d/%0d,", want.first_side, want.second_side);
                            $display(" got opened %0d bad %0d cells %0d/%0d sides %0d/%0d",
                                     out_w.opened, out_w.bad_wall, out_w.first_cell,
                                     out_w.second_cell, out_w.first_side, out_w.second_side);
                        end
                    end
                end
                recv_gap = pick_pause(recv_run);
                nx_pop   = 1'b0;
            end
            if (hold_left > 0) begin
                nx_pop = 1'b0;
            end else if (!nx_pop) begin
                if (recv_gap > 0) recv_gap--;
                else nx_pop = 1'b1;
            end
            pop_q <= nx_pop;
        end
    end

    // one long receiver hold-off so the block backs up and holds full
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && n_reported >= 200) begin
            hold_left  <= 300;
            hold_armed <= 1'b0;
        end
    end

    initial begin
        int k;
        for (k = 0; k < CELLS; k++) parent_m[k] = CELL_W'(k);
        width_m  = CFG_DATA_W'(32);
        height_m = CFG_DATA_W'(32);
        stim_w   = 32;
        stim_h   = 32;

        // full grid after reset: merges, already joined cells, walls off each edge
        add_wall(0, 0, 0);
        add_wall(0, 0, 1);
        add_wall(1, 0, 0);
        add_wall(0, 1, 1);
        add_wall(0, 0, 0);
        add_wall(31, 30, 0);
        add_wall(30, 31, 1);
        add_wall(31, 31, 0);
        add_wall(31, 31, 1);
        add_wall(0, 31, 0);
        add_wall(31, 0, 1);
        add_wall(15, 16, 1);
        add_wall(16, 15, 0);
        // zero width reads as one, oversize height as the maximum
        set_grid(0, 63);
        add_wall(5, 0, 1);
        add_wall(5, 0, 0);
        add_wall(31, 0, 1);
        add_wall(30, 0, 1);
        set_grid(33, 0);
        add_wall(0, 5, 0);
        add_wall(0, 5, 1);
        add_wall(0, 30, 0);
        add_wall(0, 31, 0);
        set_grid(1, 1);
        add_wall(0, 0, 0);
        add_wall(0, 0, 1);

        // store is never cleared, so each phase walks the forest left by the last
        set_grid(4, 4);
        random_walls(60);
        set_grid(8, 3);
        random_walls(60);
        set_grid(32, 32);
        random_walls(120);
        set_grid(1, 16);
        random_walls(40);
        set_grid(16, 1);
        random_walls(40);
        set_grid(0, 63);
        random_walls(30);
        set_grid(2, 2);
        random_walls(30);
        set_grid(63, 0);
        random_walls(30);
        set_grid(6, 5);
        random_walls(30);
        add_drain();
        random_walls(30);
        set_grid(13, 7);
        random_walls(60);
        set_grid(1, 1);
        random_walls(15);
        set_grid(32, 32);
        random_walls(80);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (wall_jobs.size() != 0 || push_q) @(posedge clk);
        while (wall_reports.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_mismatch == 0 && wall_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
src/gufwm_pkg.sv
src/gufwm_front.sv
src/gufwm_back.sv
src/grid_union_find_wall_merge_top.sv
test/grid_union_find_wall_merge_top_tb.sv
